FILE: sv/cfd_pkg.sv
// cfd_pkg: types, codes and constants shared by the crc32 frame deframer.
// Holds the transfer structs, status codes and the byte-wise crc-32 update.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

  localparam int unsigned CNT_W = 33;
  localparam logic [CNT_W-1:0] HDR_BYTES = 33'd23;
  localparam logic [CNT_W-1:0] MIN_FRAME = 33'd27;
  localparam logic [CNT_W-1:0] CRC_BYTES = 33'd4;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_SIZE_RST = 32'd4096;

  // configuration register indexes
  localparam logic [1:0] REG_MAGIC = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_MAX_SIZE = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_LEN      = 3'd2,
    ST_MAGIC    = 3'd3,
    ST_VERSION  = 3'd4,
    ST_TOO_BIG  = 3'd5,
    ST_CRC      = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  message_type;
    logic [7:0]  frame_flags;
    logic [31:0] msg_num;
    logic [15:0] chan_num;
    logic [63:0] timestamp;
    logic [31:0] body_len;
    logic [2:0]  status;
    logic        is_last;
  } out_t;

  typedef struct packed {
    logic [15:0] frame_magic;
    logic [7:0]  protocol_version;
    logic [31:0] max_frame_size;
  } cfg_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/crc32_frame_deframer.sv
// Frame deframer with crc-32 check. One frame byte is taken per transfer,
// one every clock cycle when the result side keeps up: the byte is registered,
// decoded against the frame state in the next cycle and its results (a payload
// byte, a verdict, or both on a last byte inside the payload) go into a result
// queue of OutDepth entries, from which they are handed out in order. A
// byte that ends a frame inside the payload gives two results, which the queue
// absorbs; input is held off only while the queue cannot take two more.
// Configuration registers: 0 magic, 1 version, 2 maximum frame size.
// Depends on cfd_pkg, cfd_core and cfd_out_fifo.
`timescale 1ns / 1ps
`default_nettype none

module crc32_frame_deframer
  import cfd_pkg::*;
#(
  parameter int unsigned OutDepth = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_t             out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(OutDepth + 1);

  cfg_t cfg_q;
  logic s1_valid_q;
  in_t s1_q;
  logic [1:0] res_valid;
  out_t res0, res1;
  logic [CntW-1:0] q_count;
  logic [CntW:0] q_claim;
  logic in_xfer;

  // queue entries already taken plus two reserved for the byte in flight
  assign q_claim = {1'b0, q_count} + (s1_valid_q ? (CntW+1)'(2) : '0);
  assign in_ready_o = q_claim <= (CntW+1)'(OutDepth - 2);
  assign in_xfer = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_magic <= '0;
      cfg_q.protocol_version <= '0;
      cfg_q.max_frame_size <= MAX_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAGIC:    cfg_q.frame_magic <= cfg_wdata_i[15:0];
        REG_VERSION:  cfg_q.protocol_version <= cfg_wdata_i[7:0];
        REG_MAX_SIZE: cfg_q.max_frame_size <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_data_i;
    end
  end

  cfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid_q),
    .item_i      (s1_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  cfd_out_fifo #(
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data0_i (res0),
    .data1_i (res1),
    .pop_i   (out_ready_i),
    .count_o (q_count),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  a_payload_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.item_kind == KIND_PAYLOAD
      |-> out_data_o.is_last == 1'b0 && out_data_o.status == ST_OK)
    else $error("payload transfer carries verdict fields");

endmodule

`default_nettype wire

FILE: sv/cfd_core.sv
// cfd_core: per-frame state, header capture, crc and verdict for one byte.
// Emits up to two results per byte (payload byte, then verdict).
// Depends on cfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfd_core
  import cfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire in_t        item_i,
  input  wire cfg_t       cfg_i,
  output logic [1:0]      res_valid_o,
  output out_t            res0_o,
  output out_t            res1_o
);

  logic [CNT_W-1:0] byte_count_q, byte_count_d;
  logic [31:0] crc_q, crc_d;
  logic [15:0] magic_q, magic_d;
  logic [7:0]  version_q, version_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  flags_q, flags_d;
  logic [31:0] msg_id_q, msg_id_d;
  logic [15:0] stream_q, stream_d;
  logic [63:0] ts_q, ts_d;
  logic [31:0] len_q, len_d;
  logic [31:0] got_crc_q, got_crc_d;

  logic [CNT_W-1:0] pos, pay_end, cnt_inc, want;
  logic [4:0] hp, off;
  logic [7:0] b;
  logic in_hdr, in_pay, in_crc;
  status_e status;
  out_t pay_res, verdict;

  assign pos = byte_count_q;
  assign b = item_i.data_byte;
  assign hp = pos[4:0];
  assign pay_end = HDR_BYTES + {1'b0, len_q};
  assign in_hdr = pos < HDR_BYTES;
  assign in_pay = !in_hdr && (pos < pay_end);
  assign in_crc = !in_hdr && !in_pay && (pos < pay_end + CRC_BYTES);
  assign cnt_inc = (&byte_count_q) ? byte_count_q : byte_count_q + 33'd1;

  // header capture, running crc and received crc update
  always_comb begin
    magic_d = magic_q;
    version_d = version_q;
    type_d = type_q;
    flags_d = flags_q;
    msg_id_d = msg_id_q;
    stream_d = stream_q;
    ts_d = ts_q;
    len_d = len_q;
    got_crc_d = got_crc_q;
    crc_d = crc_q;
    off = 5'd0;
    if (in_hdr) begin
      crc_d = crc_byte(crc_q, b);
      priority if (hp < 5'd2) begin
        magic_d[{hp[0], 3'b000} +: 8] = b;
      end else if (hp == 5'd2) begin
        version_d = b;
      end else if (hp == 5'd3) begin
        type_d = b;
      end else if (hp == 5'd4) begin
        flags_d = b;
      end else if (hp < 5'd9) begin
        off = hp - 5'd5;
        msg_id_d[{off[1:0], 3'b000} +: 8] = b;
      end else if (hp < 5'd11) begin
        off = hp - 5'd9;
        stream_d[{off[0], 3'b000} +: 8] = b;
      end else if (hp < 5'd19) begin
        off = hp - 5'd11;
        ts_d[{off[2:0], 3'b000} +: 8] = b;
      end else begin
        off = hp - 5'd19;
        len_d[{off[1:0], 3'b000} +: 8] = b;
      end
    end else if (in_pay) begin
      crc_d = crc_byte(crc_q, b);
    end else if (in_crc) begin
      got_crc_d = {b, got_crc_q[31:8]};
    end
  end

  // verdict checks in priority order
  assign want = MIN_FRAME + {1'b0, len_d};
  always_comb begin
    priority if (cnt_inc < MIN_FRAME) begin
      status = ST_SHORT;
    end else if (cnt_inc != want) begin
      status = ST_LEN;
    end else if (magic_d != cfg_i.frame_magic) begin
      status = ST_MAGIC;
    end else if (version_d != cfg_i.protocol_version) begin
      status = ST_VERSION;
    end else if (want > {1'b0, cfg_i.max_frame_size}) begin
      status = ST_TOO_BIG;
    end else if ((crc_d ^ CRC_ONES) != got_crc_d) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    pay_res = '0;
    pay_res.item_kind = KIND_PAYLOAD;
    pay_res.payload_byte = b;
    verdict = '0;
    verdict.item_kind = KIND_VERDICT;
    verdict.status = status;
    verdict.is_last = 1'b1;
    if (status == ST_OK) begin
      verdict.message_type = type_d;
      verdict.frame_flags = flags_d;
      verdict.msg_num = msg_id_d;
      verdict.chan_num = stream_d;
      verdict.timestamp = ts_d;
      verdict.body_len = len_d;
    end
  end

  always_comb begin
    res_valid_o = 2'b00;
    res0_o = pay_res;
    res1_o = verdict;
    if (valid_i) begin
      if (in_pay) begin
        res_valid_o = {item_i.frame_end, 1'b1};
      end else if (item_i.frame_end) begin
        res_valid_o = 2'b01;
        res0_o = verdict;
      end
    end
  end

  assign byte_count_d = item_i.frame_end ? '0 : cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      crc_q <= CRC_ONES;
      magic_q <= '0;
      version_q <= '0;
      type_q <= '0;
      flags_q <= '0;
      msg_id_q <= '0;
      stream_q <= '0;
      ts_q <= '0;
      len_q <= '0;
      got_crc_q <= '0;
    end else if (valid_i) begin
      byte_count_q <= byte_count_d;
      if (item_i.frame_end) begin
        crc_q <= CRC_ONES;
        magic_q <= '0;
        version_q <= '0;
        type_q <= '0;
        flags_q <= '0;
        msg_id_q <= '0;
        stream_q <= '0;
        ts_q <= '0;
        len_q <= '0;
        got_crc_q <= '0;
      end else begin
        crc_q <= crc_d;
        magic_q <= magic_d;
        version_q <= version_d;
        type_q <= type_d;
        flags_q <= flags_d;
        msg_id_q <= msg_id_d;
        stream_q <= stream_d;
        ts_q <= ts_d;
        len_q <= len_d;
        got_crc_q <= got_crc_d;
      end
    end
  end

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && item_i.frame_end |=> byte_count_q == '0 && crc_q == CRC_ONES)
    else $error("frame state not cleared after last byte");

  a_second_is_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o[1] |-> res_valid_o[0] && res0_o.item_kind == KIND_PAYLOAD
                       && res1_o.item_kind == KIND_VERDICT)
    else $error("second result must follow a payload byte");

endmodule

`default_nettype wire

FILE: sv/cfd_out_fifo.sv
// cfd_out_fifo: result queue that takes up to two results per cycle and
// hands out one per transfer. Depends on cfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfd_out_fifo
  import cfd_pkg::*;
#(
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [1:0]               push_i,
  input  wire out_t                     data0_i,
  input  wire out_t                     data1_i,
  input  wire logic                     pop_i,
  output logic [$clog2(Depth+1)-1:0]    count_o,
  output logic                          valid_o,
  output out_t                          data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  out_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wptr_nxt;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0] n_push;
  logic do_pop;

  // pointer step that wraps at the last entry
  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign do_pop = pop_i && (count_q != '0);
  assign n_push = {1'b0, push_i[0]} + {1'b0, push_i[1]};
  assign wptr_nxt = ptr_inc(wptr_q);
  assign wptr_d = n_push[1] ? ptr_inc(wptr_nxt) : (n_push[0] ? wptr_nxt : wptr_q);
  assign rptr_d = do_pop ? ptr_inc(rptr_q) : rptr_q;
  assign count_d = count_q + CntW'(n_push) - CntW'(do_pop);

  always_ff @(posedge clk_i) begin
    if (push_i[0]) begin
      mem_q[wptr_q] <= data0_i;
    end
    if (push_i[1]) begin
      mem_q[wptr_nxt] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      count_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      count_q <= count_d;
    end
  end

  assign count_o = count_q;
  assign valid_o = count_q != '0;
  assign data_o = mem_q[rptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overflow");

endmodule

`default_nettype wire
